### src/afs_pkg.sv
// afs_pkg: shared types and codes for the animation frame sequencer
// no dependencies; used by every module of the block
`default_nettype none

package afs_pkg;

    localparam int unsigned FRAME_W = 16;
    localparam int unsigned DELTA_W = 24;
    localparam int unsigned PERIOD_W = 24;
    localparam int unsigned LOOP_W = 16;
    localparam int unsigned ACCUM_W = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // command codes
    localparam logic [2:0] CMD_TICK = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP = 3'd2;
    localparam logic [2:0] CMD_PAUSE = 3'd3;
    localparam logic [2:0] CMD_RESUME = 3'd4;
    localparam logic [2:0] CMD_SETFRAME = 3'd5;

    // set-frame offset modes
    localparam logic [1:0] MODE_ABS = 2'd0;
    localparam logic [1:0] MODE_FROM_FIRST = 2'd1;
    localparam logic [1:0] MODE_FROM_CUR = 2'd2;
    localparam logic [1:0] MODE_BACK_LAST = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 2'd3;

    typedef struct packed {
        logic [2:0]                command;
        logic signed [DELTA_W-1:0] time_delta;
        logic signed [FRAME_W-1:0] frame_offset;
        logic [1:0]                offset_mode;
    } t_in_item;

    typedef struct packed {
        logic signed [FRAME_W-1:0] current_frame;
        logic                      running;
        logic                      is_paused;
        logic [LOOP_W-1:0]         loops_done;
        logic                      wrapped;
        logic                      finished;
    } t_out_item;

    typedef struct packed {
        logic signed [FRAME_W-1:0] first_frame;
        logic signed [FRAME_W-1:0] last_frame;
        logic [PERIOD_W-1:0]       frame_period;
        logic [LOOP_W-1:0]         repeat_limit;
    } t_cfg;

endpackage

`default_nettype wire

### src/afs_cfg_regs.sv
// afs_cfg_regs: configuration register file of the frame sequencer
// depends on afs_pkg
`default_nettype none

module afs_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [afs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [afs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output afs_pkg::t_cfg                         o_cfg
);

    afs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                afs_pkg::CFG_FIRST_FRAME: begin
                    r_cfg.first_frame <= i_cfg_data[afs_pkg::FRAME_W-1:0];
                end
                afs_pkg::CFG_LAST_FRAME: begin
                    r_cfg.last_frame <= i_cfg_data[afs_pkg::FRAME_W-1:0];
                end
                afs_pkg::CFG_FRAME_PERIOD: begin
                    r_cfg.frame_period <= i_cfg_data[afs_pkg::PERIOD_W-1:0];
                end
                afs_pkg::CFG_REPEAT_LIMIT: begin
                    r_cfg.repeat_limit <= i_cfg_data[afs_pkg::LOOP_W-1:0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### src/afs_core.sv
// afs_core: sequencer state and the per-command update logic
// depends on afs_pkg; the result is registered by the top level
`default_nettype none

module afs_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire afs_pkg::t_in_item  i_item,
    input  wire afs_pkg::t_cfg      i_cfg,
    output afs_pkg::t_out_item      o_res
);

    logic signed [afs_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic [afs_pkg::LOOP_W-1:0]         r_loop, n_loop;
    logic [afs_pkg::ACCUM_W-1:0]        r_accum, n_accum;
    logic                               r_started, n_started;
    logic                               r_paused, n_paused;

    logic                               wrapped;
    logic                               finished;
    logic                               tick_ok;
    logic [afs_pkg::ACCUM_W:0]          acc_sum;
    logic [afs_pkg::ACCUM_W-1:0]        acc_sat;
    logic [afs_pkg::ACCUM_W-1:0]        period_ext;
    logic                               adv;
    logic signed [afs_pkg::FRAME_W:0]   nxt;
    logic                               over_last;
    logic [afs_pkg::LOOP_W-1:0]         loop_inc;
    logic                               limit_hit;
    logic signed [afs_pkg::FRAME_W:0]   first_ext;
    logic signed [afs_pkg::FRAME_W:0]   last_ext;
    logic signed [afs_pkg::FRAME_W:0]   offs_ext;
    logic signed [afs_pkg::FRAME_W:0]   tgt;
    logic signed [afs_pkg::FRAME_W-1:0] tgt_clamp;

    // tick path: saturating add, one frame step at most
    assign tick_ok = r_started && !r_paused && !i_item.time_delta[afs_pkg::DELTA_W-1];
    assign acc_sum = {1'b0, r_accum}
                   + {{(afs_pkg::ACCUM_W-afs_pkg::DELTA_W+2){1'b0}},
                      i_item.time_delta[afs_pkg::DELTA_W-2:0]};
    assign acc_sat = acc_sum[afs_pkg::ACCUM_W] ? '1 : acc_sum[afs_pkg::ACCUM_W-1:0];
    assign period_ext = {{(afs_pkg::ACCUM_W-afs_pkg::PERIOD_W){1'b0}}, i_cfg.frame_period};
    assign adv = acc_sat >= period_ext;

    assign first_ext = {i_cfg.first_frame[afs_pkg::FRAME_W-1], i_cfg.first_frame};
    assign last_ext = {i_cfg.last_frame[afs_pkg::FRAME_W-1], i_cfg.last_frame};
    assign offs_ext = {i_item.frame_offset[afs_pkg::FRAME_W-1], i_item.frame_offset};

    assign nxt = {r_frame[afs_pkg::FRAME_W-1], r_frame} + 17'sd1;
    assign over_last = nxt > last_ext;
    assign loop_inc = (r_loop != '1) ? r_loop + 1'b1 : r_loop;
    assign limit_hit = (i_cfg.repeat_limit != '0) && (loop_inc >= i_cfg.repeat_limit);

    // set-frame target at 17 bits, then raised to first and lowered to last
    always_comb begin
        unique case (i_item.offset_mode)
            afs_pkg::MODE_ABS:        tgt = offs_ext;
            afs_pkg::MODE_FROM_FIRST: tgt = first_ext + offs_ext;
            afs_pkg::MODE_FROM_CUR:   tgt = {r_frame[afs_pkg::FRAME_W-1], r_frame} + offs_ext;
            afs_pkg::MODE_BACK_LAST:  tgt = last_ext - offs_ext;
        endcase
        if (last_ext < tgt || last_ext < first_ext) begin
            tgt_clamp = i_cfg.last_frame;
        end else if (tgt < first_ext) begin
            tgt_clamp = i_cfg.first_frame;
        end else begin
            tgt_clamp = tgt[afs_pkg::FRAME_W-1:0];
        end
    end

    always_comb begin
        n_frame = r_frame;
        n_loop = r_loop;
        n_accum = r_accum;
        n_started = r_started;
        n_paused = r_paused;
        wrapped = 1'b0;
        finished = 1'b0;
        unique case (i_item.command)
            afs_pkg::CMD_TICK: begin
                if (tick_ok) begin
                    n_accum = acc_sat;
                    if (adv) begin
                        if (over_last) begin
                            wrapped = 1'b1;
                            n_loop = loop_inc;
                            if (limit_hit) begin
                                finished = 1'b1;
                                n_started = 1'b0;
                                n_paused = 1'b0;
                                n_frame = '0;
                                n_loop = '0;
                                n_accum = '0;
                            end else begin
                                n_frame = i_cfg.first_frame;
                                n_accum = acc_sat - period_ext;
                            end
                        end else begin
                            n_frame = nxt[afs_pkg::FRAME_W-1:0];
                            n_accum = acc_sat - period_ext;
                        end
                    end
                end
            end
            afs_pkg::CMD_START: begin
                if (i_cfg.first_frame != i_cfg.last_frame && i_cfg.frame_period != '0) begin
                    n_started = 1'b1;
                    n_paused = 1'b0;
                    n_frame = i_cfg.first_frame;
                    n_loop = '0;
                    n_accum = '0;
                end
            end
            afs_pkg::CMD_STOP: begin
                n_started = 1'b0;
                n_paused = 1'b0;
                n_frame = '0;
                n_loop = '0;
                n_accum = '0;
            end
            afs_pkg::CMD_PAUSE:  n_paused = 1'b1;
            afs_pkg::CMD_RESUME: n_paused = 1'b0;
            afs_pkg::CMD_SETFRAME: begin
                n_frame = tgt_clamp;
                n_accum = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_loop <= '0;
            r_accum <= '0;
            r_started <= 1'b0;
            r_paused <= 1'b0;
        end else if (i_fire) begin
            r_frame <= n_frame;
            r_loop <= n_loop;
            r_accum <= n_accum;
            r_started <= n_started;
            r_paused <= n_paused;
        end
    end

    always_comb begin
        o_res.current_frame = n_frame;
        o_res.running = n_started;
        o_res.is_paused = n_paused;
        o_res.loops_done = n_loop;
        o_res.wrapped = wrapped;
        o_res.finished = finished;
    end

endmodule

`default_nettype wire

### src/animation_frame_sequencer.sv
// animation_frame_sequencer: top level with input and result registers
// depends on afs_pkg, afs_cfg_regs and afs_core
`default_nettype none

// Command-driven frame sequencer. Each beat on the input channel is one command
// (tick, start, stop, pause, resume, set frame) and yields exactly one result beat
// carrying the frame index and status after that command. One beat is taken every
// clock cycle unless the result register stalls with the input register full; a
// command travels through an input register and the state update logic into the
// result register, where it is loaded once the slot frees and taken when the output
// side is ready; a stalled result is held while the input register can take one
// more beat. The user must write configuration registers via the plain write port
// only while no command is in flight; the block does not enforce it. No read-back.
module animation_frame_sequencer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire afs_pkg::t_in_item              i_in_data,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output afs_pkg::t_out_item                  o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [afs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [afs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_in_vld;
    afs_pkg::t_in_item  r_in_item;
    logic               r_out_vld;
    afs_pkg::t_out_item r_out_item;
    afs_pkg::t_cfg      cfg;
    afs_pkg::t_out_item res;
    logic               fire;

    // item in the input register moves on when the result slot frees up
    assign fire = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;

    afs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    afs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
        if (fire) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data = r_out_item;

endmodule

`default_nettype wire

### src/afs_checker.sv
// afs_checker: port-level checks on the frame sequencer results
// depends on afs_pkg; bound to animation_frame_sequencer below
`default_nettype none

module afs_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_ready,
    input wire logic               o_out_valid,
    input wire afs_pkg::t_out_item o_out_data
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // stop on repeat limit leaves everything cleared and reports a wrap
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.finished |->
            o_out_data.wrapped && !o_out_data.running && !o_out_data.is_paused
            && o_out_data.loops_done == '0 && o_out_data.current_frame == '0)
        else $error("finished result without cleared state");

    // loops are only counted while running
    a_idle_no_loops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.running |-> o_out_data.loops_done == '0)
        else $error("loop count nonzero while not running");

    // a plain wrap keeps the sequence running
    a_wrap_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.wrapped && !o_out_data.finished |->
            o_out_data.running && !o_out_data.is_paused)
        else $error("wrap reported while not running");

endmodule

bind animation_frame_sequencer afs_checker u_afs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_ready (i_out_ready),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data)
);

`default_nettype wire
